// File: design/pbr_pkg.sv
package pbr_pkg;

  localparam int BLOCK_COUNT_BITS_DEF = 10;

  // configuration register indexes
  localparam logic [2:0] REG_FACE_MODES   = 3'd0;
  localparam logic [2:0] REG_EXTENT_X     = 3'd1;
  localparam logic [2:0] REG_EXTENT_Y     = 3'd2;
  localparam logic [2:0] REG_EXTENT_Z     = 3'd3;
  localparam logic [2:0] REG_INV_X        = 3'd4;
  localparam logic [2:0] REG_INV_Y        = 3'd5;
  localparam logic [2:0] REG_INV_Z        = 3'd6;
  localparam logic [2:0] REG_BLOCK_COUNTS = 3'd7;

  // face handling modes
  localparam logic [1:0] MODE_PERIODIC = 2'd0;
  localparam logic [1:0] MODE_REFLECT  = 2'd1;

  localparam logic [4:0] DIR_STAY = 5'd13;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_mom_x;
    logic signed [31:0] new_mom_y;
    logic signed [31:0] new_mom_z;
    logic [4:0]         dest_dir;
    logic               dropped;
    logic               range_error;
  } out_req_t;

  // candidate action per axis, chosen in the front part
  typedef enum logic [2:0] {
    ACT_KEEP,
    ACT_WRAP_LO,
    ACT_WRAP_HI,
    ACT_REFL_LO,
    ACT_REFL_HI,
    ACT_DROP
  } act_t;

  typedef struct packed {
    act_t               act;
    logic signed [32:0] xnew;   // candidate position, already saturated
    logic signed [31:0] mom;
  } axis_cls_t;

  // request handed from front to back
  typedef struct packed {
    logic               in_patch;
    axis_cls_t [2:0]    ax;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } cls_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: design/particle_boundary_router_core.sv
// Particle boundary router.
// Input channel in_valid/in_stall/in_data carries one particle per request
// (position and momentum, Q16.16). Output channel out_valid/out_stall/
// out_data carries one result per request: new position and momentum,
// neighbor direction (13 stays), drop and range flags.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must do so only while idle, as the block does not enforce it. A request
// loads the first front stage (block index multiply) at the accepting edge,
// then the face decision stage, one queue slot, the recheck multiply and the
// output register feeding out_valid. Throughput is one request per cycle while
// out_stall is low; each axis has one 33x33 multiplier in front and one in back.
// A four-entry queue separates the parts: the front accepts while the queue
// plus its two stages hold at most three requests, so when streaming,
// in_stall rises in the cycle after the receiver starts holding out_stall.
// Results held under out_stall never change. Synchronous reset clears all
// valid flags, the queue and the configuration registers to zero.
module particle_boundary_router_core #(
  parameter int BLOCK_COUNT_BITS = pbr_pkg::BLOCK_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pbr_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pbr_pkg::out_req_t out_data,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [((3 * BLOCK_COUNT_BITS > 32) ? 3 * BLOCK_COUNT_BITS : 32)-1:0] cfg_wdata
);

  localparam int QW = $bits(pbr_pkg::cls_req_t) + 96;

  logic [17:0]                     face_modes_r;
  logic [2:0][30:0]                extent_r;
  logic [2:0][31:0]                inv_block_r;
  logic [3*BLOCK_COUNT_BITS-1:0]   block_counts_r;

  logic                            in_fire;
  logic                            f_s1_valid;
  logic                            f_valid;
  pbr_pkg::cls_req_t               f_data;
  logic [2:0][31:0]                f_xnew;
  logic [2:0][BLOCK_COUNT_BITS-1:0] cnt;
  logic                            q_pop, q_empty;
  logic [2:0]                      q_count;
  logic [QW-1:0]                   q_rd;
  logic [1:0]                      inflight;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_modes_r   <= '0;
      extent_r       <= '0;
      inv_block_r    <= '0;
      block_counts_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pbr_pkg::REG_FACE_MODES:   face_modes_r   <= cfg_wdata[17:0];
        pbr_pkg::REG_EXTENT_X:     extent_r[0]    <= cfg_wdata[30:0];
        pbr_pkg::REG_EXTENT_Y:     extent_r[1]    <= cfg_wdata[30:0];
        pbr_pkg::REG_EXTENT_Z:     extent_r[2]    <= cfg_wdata[30:0];
        pbr_pkg::REG_INV_X:        inv_block_r[0] <= cfg_wdata[31:0];
        pbr_pkg::REG_INV_Y:        inv_block_r[1] <= cfg_wdata[31:0];
        pbr_pkg::REG_INV_Z:        inv_block_r[2] <= cfg_wdata[31:0];
        pbr_pkg::REG_BLOCK_COUNTS: block_counts_r <= cfg_wdata[3*BLOCK_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front pipe always advances; stall input when queue plus pipe could overflow
  assign inflight = 2'(f_valid) + 2'(f_s1_valid);
  assign in_stall = ({1'b0, q_count} + {2'b0, inflight}) >= 4'd3 && q_count != 3'd0
                    ? ({1'b0, q_count} + {2'b0, inflight} + 4'd1 > 4'd4) : 1'b0;
  assign in_fire  = in_valid && !in_stall;

  pbr_front #(.BLOCK_COUNT_BITS(BLOCK_COUNT_BITS)) u_front (
    .clk, .rst_n, .adv(1'b1), .in_fire, .in_data,
    .face_modes(face_modes_r), .extent(extent_r), .inv_block(inv_block_r),
    .block_counts(block_counts_r), .s1_valid(f_s1_valid),
    .cls_valid(f_valid), .cls_data(f_data), .cls_xnew(f_xnew), .cls_cnt(cnt)
  );

  pbr_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .wr_en(f_valid), .wr_data({f_data, f_xnew}),
    .rd_en(q_pop), .rd_data(q_rd), .empty(q_empty), .count(q_count)
  );

  pbr_back #(.BLOCK_COUNT_BITS(BLOCK_COUNT_BITS)) u_back (
    .clk, .rst_n, .q_valid(!q_empty),
    .q_data(q_rd[QW-1:96]), .q_xnew(q_rd[95:0]), .q_pop,
    .extent(extent_r), .inv_block(inv_block_r), .cnt,
    .out_valid, .out_data, .out_stall
  );

endmodule

// File: design/pbr_front.sv
// Front part: block index per axis, face decision, candidate position.
module pbr_front #(
  parameter int BLOCK_COUNT_BITS = pbr_pkg::BLOCK_COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_fire,
  input  pbr_pkg::in_req_t                in_data,
  input  logic [17:0]                     face_modes,
  input  logic [2:0][30:0]                extent,
  input  logic [2:0][31:0]                inv_block,
  input  logic [3*BLOCK_COUNT_BITS-1:0]   block_counts,
  output logic                            s1_valid,
  output logic                            cls_valid,
  output pbr_pkg::cls_req_t               cls_data,
  output logic [2:0][31:0]                cls_xnew,
  output logic [2:0][BLOCK_COUNT_BITS-1:0] cls_cnt
);

  logic                  s1_valid_r;
  logic [2:0][31:0]      s1_pos_r, s1_mom_r;
  logic [2:0][32:0]      s1_bhi_r;
  logic                  s2_valid_r;
  pbr_pkg::cls_req_t     s2_r;
  logic [2:0][BLOCK_COUNT_BITS-1:0] cnt;
  pbr_pkg::cls_req_t     s2_nxt;
  logic [2:0][31:0]      s2_xn_r;
  logic [2:0][31:0]      s2_xn_nxt;

  always_comb begin
    for (int d = 0; d < 3; d++) cnt[d] = block_counts[d*BLOCK_COUNT_BITS +: BLOCK_COUNT_BITS];
  end

  // stage 1: multiply, keep the integer part of the product (floor)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos_r <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
      s1_mom_r <= {in_data.mom_z, in_data.mom_y, in_data.mom_x};
      s1_bhi_r[0] <= 33'(($signed({in_data.pos_x[31], in_data.pos_x})
                     * $signed({33'd0, inv_block[0]})) >>> 32);
      s1_bhi_r[1] <= 33'(($signed({in_data.pos_y[31], in_data.pos_y})
                     * $signed({33'd0, inv_block[1]})) >>> 32);
      s1_bhi_r[2] <= 33'(($signed({in_data.pos_z[31], in_data.pos_z})
                     * $signed({33'd0, inv_block[2]})) >>> 32);
    end
  end

  // stage 2: classify each axis and form the candidate position
  always_comb begin
    logic signed [32:0] b;
    logic signed [33:0] xs, xm;
    logic [1:0] lom, him;
    logic loe, hie, ge;
    s2_nxt = '0;
    s2_nxt.in_patch = 1'b1;
    s2_nxt.pos_x = s1_pos_r[0];
    s2_nxt.pos_y = s1_pos_r[1];
    s2_nxt.pos_z = s1_pos_r[2];
    for (int d = 0; d < 3; d++) begin
      b   = s1_bhi_r[d];
      xs  = 34'(signed'(s1_pos_r[d]));
      xm  = {3'b000, extent[d]};
      lom = face_modes[4*d +: 2];
      him = face_modes[4*d+2 +: 2];
      loe = face_modes[12+2*d];
      hie = face_modes[13+2*d];
      ge  = (b >= $signed({1'b0, 32'(cnt[d])}));
      s2_nxt.ax[d].mom  = s1_mom_r[d];
      s2_nxt.ax[d].xnew = 33'(signed'(s1_pos_r[d]));
      s2_nxt.ax[d].act  = pbr_pkg::ACT_KEEP;
      if (b < 0) begin
        s2_nxt.in_patch = 1'b0;
        if (!loe || lom == pbr_pkg::MODE_PERIODIC) begin
          s2_nxt.ax[d].act  = pbr_pkg::ACT_WRAP_LO;
          s2_nxt.ax[d].xnew = 33'(pbr_pkg::sat32(xs + xm));
        end else if (lom == pbr_pkg::MODE_REFLECT) begin
          s2_nxt.ax[d].act  = pbr_pkg::ACT_REFL_LO;
          s2_nxt.ax[d].xnew = 33'(pbr_pkg::sat32(-xs));
        end else begin
          s2_nxt.ax[d].act = pbr_pkg::ACT_DROP;
        end
      end else if (ge) begin
        s2_nxt.in_patch = 1'b0;
        if (!hie || him == pbr_pkg::MODE_PERIODIC) begin
          s2_nxt.ax[d].act  = pbr_pkg::ACT_WRAP_HI;
          s2_nxt.ax[d].xnew = 33'(pbr_pkg::sat32(xs - xm));
        end else if (him == pbr_pkg::MODE_REFLECT) begin
          s2_nxt.ax[d].act  = pbr_pkg::ACT_REFL_HI;
          s2_nxt.ax[d].xnew = 33'(pbr_pkg::sat32((xm <<< 1) - xs));
        end else begin
          s2_nxt.ax[d].act = pbr_pkg::ACT_DROP;
        end
      end
      s2_xn_nxt[d] = s2_nxt.ax[d].xnew[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r    <= s2_nxt;
      s2_xn_r <= s2_xn_nxt;
    end
  end

  assign s1_valid  = s1_valid_r;
  assign cls_valid = s2_valid_r;
  assign cls_data  = s2_r;
  assign cls_xnew  = s2_xn_r;
  assign cls_cnt   = cnt;

endmodule

// File: design/pbr_queue.sv
// Short queue between front and back parts.
module pbr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty,
  output logic [2:0]   count
);

  logic [W-1:0] mem_r [4];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign rd_data = mem_r[rp_r];
  assign empty   = (cnt_r == 3'd0);
  assign count   = cnt_r;

endmodule

// File: design/pbr_back.sv
// Back part: recheck candidate block index, finish each axis, merge result.
module pbr_back #(
  parameter int BLOCK_COUNT_BITS = pbr_pkg::BLOCK_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  pbr_pkg::cls_req_t                q_data,
  input  logic [2:0][31:0]                 q_xnew,
  output logic                             q_pop,
  input  logic [2:0][30:0]                 extent,
  input  logic [2:0][31:0]                 inv_block,
  input  logic [2:0][BLOCK_COUNT_BITS-1:0] cnt,
  output logic                             out_valid,
  output pbr_pkg::out_req_t                out_data,
  input  logic                             out_stall
);

  logic               b1_valid_r;
  pbr_pkg::cls_req_t  b1_r;
  logic [2:0][32:0]   b1_bhi_r;
  logic               b1_adv;
  logic               ov_r;
  pbr_pkg::out_req_t  od_r, od_nxt;

  // output register frees when taken; the recheck stage moves with it
  assign b1_adv = !ov_r || !out_stall;
  assign q_pop  = q_valid && (b1_adv || !b1_valid_r);

  // recheck stage: block index of the candidate position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (b1_adv || !b1_valid_r) begin
      b1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv || !b1_valid_r) begin
      b1_r <= q_data;
      for (int d = 0; d < 3; d++) begin
        b1_bhi_r[d] <= 33'(($signed({q_xnew[d][31], q_xnew[d]})
                       * $signed({33'd0, inv_block[d]})) >>> 32);
      end
    end
  end

  // finish axes and pack the result
  always_comb begin
    logic signed [31:0] x, pin;
    logic signed [31:0] m;
    logic signed [32:0] b;
    logic [1:0] dir [3];
    logic drop, rerr, ge;
    drop = 1'b0;
    rerr = 1'b0;
    od_nxt = '0;
    for (int d = 0; d < 3; d++) begin
      pin = (d == 0) ? b1_r.pos_x : (d == 1) ? b1_r.pos_y : b1_r.pos_z;
      x = b1_r.in_patch ? pin : b1_r.ax[d].xnew[31:0];
      m = b1_r.ax[d].mom;
      b = b1_bhi_r[d];
      ge = (b >= $signed({1'b0, 32'(cnt[d])}));
      dir[d] = 2'd1;
      if (!b1_r.in_patch) begin
        case (b1_r.ax[d].act)
          pbr_pkg::ACT_WRAP_LO: begin
            dir[d] = 2'd0;
            if (ge) begin
              x = '0;
              dir[d] = 2'd1;
            end
          end
          pbr_pkg::ACT_WRAP_HI: begin
            dir[d] = 2'd2;
            if (b < 0) x = '0;
          end
          pbr_pkg::ACT_REFL_LO: m = pbr_pkg::sat32(-34'(m));
          pbr_pkg::ACT_REFL_HI: begin
            m = pbr_pkg::sat32(-34'(m));
            if (ge) x = pbr_pkg::sat32(34'(x) - 34'sd1);
          end
          pbr_pkg::ACT_DROP: drop = 1'b1;
          default: ;
        endcase
        if (!drop) begin
          if (x == -32'sd1) x = '0;
          if (x < 0 || 33'(x) > $signed({2'b00, extent[d]})) rerr = 1'b1;
        end
      end
      case (d)
        0: begin od_nxt.new_pos_x = x; od_nxt.new_mom_x = m; end
        1: begin od_nxt.new_pos_y = x; od_nxt.new_mom_y = m; end
        default: begin od_nxt.new_pos_z = x; od_nxt.new_mom_z = m; end
      endcase
    end
    od_nxt.dest_dir = 5'(dir[0]) + 5'(3 * dir[1]) + 5'(9 * dir[2]);
    od_nxt.range_error = rerr;
    od_nxt.dropped = drop;
    // drop restores the inputs
    if (drop) begin
      od_nxt.new_pos_x = b1_r.pos_x;
      od_nxt.new_pos_y = b1_r.pos_y;
      od_nxt.new_pos_z = b1_r.pos_z;
      od_nxt.new_mom_x = b1_r.ax[0].mom;
      od_nxt.new_mom_y = b1_r.ax[1].mom;
      od_nxt.new_mom_z = b1_r.ax[2].mom;
      od_nxt.dest_dir  = pbr_pkg::DIR_STAY;
      od_nxt.range_error = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (b1_adv) begin
      ov_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv) od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// File: design/pbr_checker.sv
module pbr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input pbr_pkg::out_req_t out_data
);

  // held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // dropped result goes nowhere
  a_drop_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> out_data.dest_dir == pbr_pkg::DIR_STAY)
    else $error("dropped result has a direction");

  a_drop_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> !out_data.range_error)
    else $error("dropped result flags range");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.dest_dir <= 5'd26)
    else $error("direction out of range");

endmodule

bind particle_boundary_router_core pbr_checker u_pbr_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);
